FILE: hdl/xml_tag_tokenizer_defines.svh
// assertion macros for the xml tag tokenizer checker
// no dependencies; included by files that hold concurrent assertions
`ifndef XML_TAG_TOKENIZER_DEFINES_SVH
`define XML_TAG_TOKENIZER_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define XTT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define XTT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/xtt_pkg.sv
// shared types and constants for the xml tag tokenizer
// no dependencies; used by xtt_classify, xml_tag_tokenizer and xtt_checker
`default_nettype none

package xtt_pkg;

   // parse phases
   localparam logic [3:0] PH_FIND_START   = 4'd0;
   localparam logic [3:0] PH_EXPECT_TOKEN = 4'd1;
   localparam logic [3:0] PH_TOKEN_END    = 4'd2;
   localparam logic [3:0] PH_SKIP_SPACE   = 4'd3;
   localparam logic [3:0] PH_GET_ATTR     = 4'd4;
   localparam logic [3:0] PH_QUOTED       = 4'd5;
   localparam logic [3:0] PH_UNQUOTED     = 4'd6;
   localparam logic [3:0] PH_EXPECT_GT    = 4'd7;
   localparam logic [3:0] PH_MAYBE_GT     = 4'd8;
   localparam logic [3:0] PH_ESCAPE       = 4'd9;

   // byte roles
   localparam logic [2:0] ROLE_OUTSIDE = 3'd0;
   localparam logic [2:0] ROLE_OPEN    = 3'd1;
   localparam logic [2:0] ROLE_NAME    = 3'd2;
   localparam logic [2:0] ROLE_VALUE   = 3'd3;
   localparam logic [2:0] ROLE_DELIM   = 3'd4;

   // abandon causes
   localparam logic [1:0] CAUSE_NONE   = 2'd0;
   localparam logic [1:0] CAUSE_SYNTAX = 2'd1;
   localparam logic [1:0] CAUSE_LENGTH = 2'd2;
   localparam logic [1:0] CAUSE_TOKENS = 2'd3;

   // characters
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   localparam logic [15:0] MAX_LEN_RESET = 16'd4096;

   // widest token counter over the supported token limits
   localparam int unsigned TOKEN_CNT_MAX_W = 7;

   typedef struct packed {
      logic [3:0]  phase;
      logic        quote_double;
      logic [15:0] length;
   } xtt_state_type;

   typedef struct packed {
      logic [2:0] role;
      logic [3:0] token_index;
      logic       name_start;
      logic       value_open;
      logic       element_done;
      logic       abandoned;
      logic [1:0] abandon_cause;
   } xtt_result_type;

   function automatic logic is_letter(input logic [7:0] b);
      return b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return b inside {8'h20, [8'h09:8'h0D]};
   endfunction

endpackage

`default_nettype wire

FILE: hdl/xtt_classify.sv
// per-byte decision of the tag tokenizer: next parse state and byte label
// depends on xtt_pkg
`default_nettype none

module xtt_classify #(
   parameter  int unsigned MAX_TOKENS = 16,
   localparam int unsigned CNT_W      = $clog2(MAX_TOKENS + 1)
) (
   input  wire logic [7:0]            byte_in,
   input  wire xtt_pkg::xtt_state_type cur_state,
   input  wire logic [CNT_W-1:0]      cur_count,
   input  wire logic [15:0]           max_len,
   output xtt_pkg::xtt_state_type     nxt_state,
   output logic [CNT_W-1:0]           nxt_count,
   output xtt_pkg::xtt_result_type    result
);

   logic [3:0]                          phase;
   logic                                new_token;
   logic [2:0]                          role;
   logic                                ns;
   logic                                vo;
   logic                                done;
   logic [1:0]                          cause;
   logic [CNT_W-1:0]                    cnt_m1;
   logic [xtt_pkg::TOKEN_CNT_MAX_W-1:0] cnt_wide;
   logic                                letter;
   logic                                space;

   assign letter   = xtt_pkg::is_letter(byte_in);
   assign space    = xtt_pkg::is_space(byte_in);

   always_comb begin
      nxt_state = cur_state;
      nxt_count = cur_count;
      role      = xtt_pkg::ROLE_OUTSIDE;
      ns        = 1'b0;
      vo        = 1'b0;
      done      = 1'b0;
      cause     = xtt_pkg::CAUSE_NONE;
      new_token = 1'b0;
      // codes past the last phase fall back to searching for a tag
      phase     = (cur_state.phase > xtt_pkg::PH_ESCAPE) ? xtt_pkg::PH_FIND_START
                                                         : cur_state.phase;
      nxt_state.phase = phase;

      if (phase == xtt_pkg::PH_FIND_START) begin
         if (byte_in == xtt_pkg::CH_LT) begin
            nxt_count = '0;
            if (max_len == 16'd0) begin
               cause = xtt_pkg::CAUSE_LENGTH;
            end else begin
               nxt_state.length = 16'd1;
               role             = xtt_pkg::ROLE_OPEN;
               nxt_state.phase  = xtt_pkg::PH_EXPECT_TOKEN;
            end
         end
      end else if (cur_state.length >= max_len) begin
         cause = xtt_pkg::CAUSE_LENGTH;
      end else begin
         nxt_state.length = cur_state.length + 16'd1;
         case (phase)
            xtt_pkg::PH_EXPECT_TOKEN: begin
               if (letter) new_token = 1'b1;
               else cause = xtt_pkg::CAUSE_SYNTAX;
            end
            xtt_pkg::PH_TOKEN_END: begin
               if (letter || byte_in == xtt_pkg::CH_UNDER) begin
                  role = xtt_pkg::ROLE_NAME;
               end else if (byte_in == xtt_pkg::CH_EQ) begin
                  role            = xtt_pkg::ROLE_DELIM;
                  nxt_state.phase = xtt_pkg::PH_GET_ATTR;
               end else if (byte_in == xtt_pkg::CH_SLASH) begin
                  role            = xtt_pkg::ROLE_DELIM;
                  nxt_state.phase = xtt_pkg::PH_EXPECT_GT;
               end else if (byte_in == xtt_pkg::CH_GT) begin
                  role = xtt_pkg::ROLE_DELIM;
                  done = 1'b1;
               end else if (space) begin
                  role            = xtt_pkg::ROLE_DELIM;
                  nxt_state.phase = xtt_pkg::PH_SKIP_SPACE;
               end else begin
                  cause = xtt_pkg::CAUSE_SYNTAX;
               end
            end
            xtt_pkg::PH_SKIP_SPACE: begin
               if (letter) begin
                  new_token = 1'b1;
               end else if (byte_in == xtt_pkg::CH_SLASH) begin
                  role            = xtt_pkg::ROLE_DELIM;
                  nxt_state.phase = xtt_pkg::PH_EXPECT_GT;
               end else if (byte_in == xtt_pkg::CH_GT) begin
                  role = xtt_pkg::ROLE_DELIM;
                  done = 1'b1;
               end else if (space) begin
                  role = xtt_pkg::ROLE_DELIM;
               end else begin
                  cause = xtt_pkg::CAUSE_SYNTAX;
               end
            end
            xtt_pkg::PH_GET_ATTR: begin
               vo = 1'b1;
               if (byte_in == xtt_pkg::CH_SQUOTE || byte_in == xtt_pkg::CH_DQUOTE) begin
                  role                   = xtt_pkg::ROLE_DELIM;
                  nxt_state.quote_double = (byte_in == xtt_pkg::CH_DQUOTE);
                  nxt_state.phase        = xtt_pkg::PH_QUOTED;
               end else begin
                  role            = xtt_pkg::ROLE_VALUE;
                  nxt_state.phase = xtt_pkg::PH_UNQUOTED;
               end
            end
            xtt_pkg::PH_QUOTED: begin
               if (byte_in == (cur_state.quote_double ? xtt_pkg::CH_DQUOTE
                                                      : xtt_pkg::CH_SQUOTE)) begin
                  role            = xtt_pkg::ROLE_DELIM;
                  nxt_state.phase = xtt_pkg::PH_SKIP_SPACE;
               end else begin
                  role = xtt_pkg::ROLE_VALUE;
                  if (byte_in == xtt_pkg::CH_BSLASH) nxt_state.phase = xtt_pkg::PH_ESCAPE;
               end
            end
            xtt_pkg::PH_ESCAPE: begin
               role            = xtt_pkg::ROLE_VALUE;
               nxt_state.phase = xtt_pkg::PH_QUOTED;
            end
            xtt_pkg::PH_UNQUOTED: begin
               if (byte_in == xtt_pkg::CH_GT) begin
                  role = xtt_pkg::ROLE_DELIM;
                  done = 1'b1;
               end else if (byte_in == xtt_pkg::CH_SLASH) begin
                  role            = xtt_pkg::ROLE_VALUE;
                  nxt_state.phase = xtt_pkg::PH_MAYBE_GT;
               end else if (space) begin
                  role            = xtt_pkg::ROLE_DELIM;
                  nxt_state.phase = xtt_pkg::PH_SKIP_SPACE;
               end else begin
                  role = xtt_pkg::ROLE_VALUE;
               end
            end
            xtt_pkg::PH_MAYBE_GT: begin
               if (byte_in == xtt_pkg::CH_GT) begin
                  role = xtt_pkg::ROLE_DELIM;
                  done = 1'b1;
               end else begin
                  role            = xtt_pkg::ROLE_VALUE;
                  nxt_state.phase = xtt_pkg::PH_UNQUOTED;
               end
            end
            default: begin
               // expecting the '>' after a slash
               if (byte_in == xtt_pkg::CH_GT) begin
                  role = xtt_pkg::ROLE_DELIM;
                  done = 1'b1;
               end else begin
                  cause = xtt_pkg::CAUSE_SYNTAX;
               end
            end
         endcase

         if (new_token) begin
            if (cur_count >= CNT_W'(MAX_TOKENS)) begin
               cause = xtt_pkg::CAUSE_TOKENS;
            end else begin
               nxt_count       = cur_count + CNT_W'(1);
               role            = xtt_pkg::ROLE_NAME;
               ns              = 1'b1;
               nxt_state.phase = xtt_pkg::PH_TOKEN_END;
            end
         end
      end

      // token number of this byte, taken before an element end clears the count
      cnt_m1   = nxt_count - CNT_W'(1);
      cnt_wide = xtt_pkg::TOKEN_CNT_MAX_W'(cnt_m1);

      result.role          = role;
      result.token_index   = 4'd0;
      result.name_start    = ns;
      result.value_open    = vo;
      result.element_done  = done;
      result.abandoned     = (cause != xtt_pkg::CAUSE_NONE);
      result.abandon_cause = cause;

      if (cause != xtt_pkg::CAUSE_NONE) begin
         result.role         = xtt_pkg::ROLE_OUTSIDE;
         result.name_start   = 1'b0;
         result.value_open   = 1'b0;
         result.element_done = 1'b0;
      end else if (role != xtt_pkg::ROLE_OUTSIDE && nxt_count != '0) begin
         result.token_index = cnt_wide[3:0];
      end

      if (cause != xtt_pkg::CAUSE_NONE || done) begin
         nxt_state.phase  = xtt_pkg::PH_FIND_START;
         nxt_state.length = 16'd0;
         nxt_count        = '0;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/xml_tag_tokenizer.sv
// Byte-stream tag tokenizer. Takes one character per transfer and returns one label per
// character: its role, token index and the name-start, value-open, element-done and
// abandon flags with the abandon cause. Throughput is one byte per clock unless the
// result side stalls; each byte passes an input register and then a result register
// before its label appears. The one-byte-per-clock figure is set by the parse-state
// update, combinational from the input register to the state and result registers.
// The element length limit is written on the csr port (reset 4096); the user must
// write it only while no byte is in flight (not enforced); csr_ready is always high.
// depends on xtt_pkg and xtt_classify
`default_nettype none

module xml_tag_tokenizer #(
   parameter int unsigned MAX_TOKENS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_byte_in,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_role,
   output logic [3:0]       rsp_token_index,
   output logic             rsp_name_start,
   output logic             rsp_value_open,
   output logic             rsp_element_done,
   output logic             rsp_abandoned,
   output logic [1:0]       rsp_abandon_cause,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_max_element_bytes
);

   localparam int unsigned CNT_W = $clog2(MAX_TOKENS + 1);

   logic                    in_valid_ff;
   logic                    in_valid_in;
   logic [7:0]              in_byte_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   xtt_pkg::xtt_result_type rsp_result_ff;
   xtt_pkg::xtt_state_type  state_ff;
   xtt_pkg::xtt_state_type  state_in;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic [15:0]             max_len_ff;
   xtt_pkg::xtt_result_type result;
   logic                    out_free;
   logic                    advance;
   logic                    accept;

   // result register is free when empty or being taken this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   xtt_classify #(
      .MAX_TOKENS (MAX_TOKENS)
   ) u_classify (
      .byte_in   (in_byte_ff),
      .cur_state (state_ff),
      .cur_count (count_ff),
      .max_len   (max_len_ff),
      .nxt_state (state_in),
      .nxt_count (count_in),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
         count_ff     <= '0;
         max_len_ff   <= xtt_pkg::MAX_LEN_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
            count_ff <= count_in;
         end
         if (csr_valid && csr_ready) max_len_ff <= csr_max_element_bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) in_byte_ff <= req_byte_in;
      if (advance) rsp_result_ff <= result;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_role          = rsp_result_ff.role;
   assign rsp_token_index   = rsp_result_ff.token_index;
   assign rsp_name_start    = rsp_result_ff.name_start;
   assign rsp_value_open    = rsp_result_ff.value_open;
   assign rsp_element_done  = rsp_result_ff.element_done;
   assign rsp_abandoned     = rsp_result_ff.abandoned;
   assign rsp_abandon_cause = rsp_result_ff.abandon_cause;

endmodule

`default_nettype wire

FILE: hdl/xtt_checker.sv
// port-level checks for the xml tag tokenizer, bound to the top level
// depends on xtt_pkg, xml_tag_tokenizer_defines.svh and xml_tag_tokenizer
`default_nettype none
`include "xml_tag_tokenizer_defines.svh"

module xtt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [2:0]  rsp_role,
   input wire logic [3:0]  rsp_token_index,
   input wire logic        rsp_name_start,
   input wire logic        rsp_value_open,
   input wire logic        rsp_element_done,
   input wire logic        rsp_abandoned,
   input wire logic [1:0]  rsp_abandon_cause
);

   logic rsp_busy;
   logic drop_clean;

   assign rsp_busy   = rsp_valid && rsp_stall;
   assign drop_clean = rsp_role == xtt_pkg::ROLE_OUTSIDE && rsp_token_index == 4'd0
                       && !rsp_name_start && !rsp_value_open && !rsp_element_done;

   // abandon flag and cause agree
   `XTT_ASSERT_NOW(a_abandon_cause, clock, reset, rsp_valid,
      rsp_abandoned == (rsp_abandon_cause != xtt_pkg::CAUSE_NONE),
      "abandon flag and cause disagree")

   // a dropped byte carries no other label
   `XTT_ASSERT_NOW(a_drop_clean, clock, reset, rsp_valid && rsp_abandoned, drop_clean,
      "dropped byte carries a label")

   // a completed element ends on a delimiter
   `XTT_ASSERT_NOW(a_done_delim, clock, reset, rsp_valid && rsp_element_done,
      rsp_role == xtt_pkg::ROLE_DELIM && !rsp_abandoned,
      "element done on a non-delimiter byte")

   // a name start is a name byte
   `XTT_ASSERT_NOW(a_name_start, clock, reset, rsp_valid && rsp_name_start,
      rsp_role == xtt_pkg::ROLE_NAME && !rsp_value_open,
      "name start on a non-name byte")

   // stalled result holds
   `XTT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_busy,
      rsp_valid && $stable(rsp_role) && $stable(rsp_token_index)
      && $stable(rsp_abandon_cause),
      "stalled result changed")

endmodule

bind xml_tag_tokenizer xtt_checker u_xtt_checker (.*);

`default_nettype wire
